// ===== src/assert_macros.svh =====
// assertion macros shared by the sprite sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sfs_pkg.sv =====
// types and codes shared by the sprite frame sequencer
`default_nettype none

package sfs_pkg;

    localparam int CFG_DATA_W = 9;

    typedef logic [1:0] cfg_addr_t;
    typedef logic [1:0] op_code_t;
    typedef logic [2:0] play_mode_t;

    localparam cfg_addr_t CFG_SPEED       = 2'd0;
    localparam cfg_addr_t CFG_FRAME_COUNT = 2'd1;
    localparam cfg_addr_t CFG_LOOP_FRAME  = 2'd2;
    localparam cfg_addr_t CFG_PLAY_MODE   = 2'd3;

    localparam op_code_t OP_TICK    = 2'd0;
    localparam op_code_t OP_SET     = 2'd1;
    localparam op_code_t OP_WRITE   = 2'd2;
    localparam op_code_t OP_RESTART = 2'd3;

    localparam play_mode_t MODE_LOOP         = 3'd0;
    localparam play_mode_t MODE_LOOP_ONCE    = 3'd1;
    localparam play_mode_t MODE_REVERSE      = 3'd2;
    localparam play_mode_t MODE_REVERSE_ONCE = 3'd3;
    localparam play_mode_t MODE_PING_PONG    = 3'd4;

    localparam logic [7:0] SPEED_RESET = 8'd4;
    localparam logic [8:0] COUNT_RESET = 9'd1;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [7:0]  disp_x;
        logic [7:0]  disp_y;
    } tile_t;

    typedef struct packed {
        op_code_t    op;
        logic        hold;
        logic [15:0] index;
        logic [15:0] tile_x;
        logic [15:0] tile_y;
        logic [7:0]  tile_width;
        logic [7:0]  tile_height;
        logic [7:0]  tile_disp_x;
        logic [7:0]  tile_disp_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  frame;
        logic        done_res;
        logic [15:0] spr_x;
        logic [15:0] spr_y;
        logic [7:0]  spr_width;
        logic [7:0]  spr_height;
        logic [7:0]  spr_disp_x;
        logic [7:0]  spr_disp_y;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/sfs_front.sv =====
// front end: config registers, animation state and request decode
`default_nettype none

module sfs_front #(
    parameter int MAX_FRAMES = 256,
    parameter type req_t = logic
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire sfs_pkg::cfg_addr_t            cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire sfs_pkg::in_item_t             in_data,
    input  wire logic                          q_full,
    output logic                               q_push,
    output req_t                               q_req
);
    import sfs_pkg::*;

    localparam int FW = $clog2(MAX_FRAMES);

    logic [7:0]    speed_reg;
    logic [8:0]    count_reg;
    logic [7:0]    loop_reg;
    play_mode_t    mode_reg;

    logic [FW-1:0] cur_reg, cur_next;
    logic [7:0]    timer_reg, timer_next;
    logic          fin_reg, fin_next;

    logic [FW-1:0] last;
    logic [FW-1:0] wrap;
    logic [FW-1:0] f0;
    logic [FW-1:0] fa;
    logic [FW-1:0] g;
    logic [7:0]    t1;
    logic          step;
    logic          wen;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign q_push    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= SPEED_RESET;
            count_reg <= COUNT_RESET;
            loop_reg  <= '0;
            mode_reg  <= MODE_LOOP;
            cur_reg   <= '0;
            timer_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SPEED:       speed_reg <= cfg_data[7:0];
                    CFG_FRAME_COUNT: count_reg <= cfg_data;
                    CFG_LOOP_FRAME:  loop_reg  <= cfg_data[7:0];
                    CFG_PLAY_MODE:   mode_reg  <= cfg_data[2:0];
                    default:         ;
                endcase
            end
            cur_reg   <= cur_next;
            timer_reg <= timer_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        // last frame in use, count of zero acts as one
        if (count_reg == 9'd0)
            last = '0;
        else if (32'(count_reg) > MAX_FRAMES)
            last = FW'(MAX_FRAMES - 1);
        else
            last = FW'(count_reg - 9'd1);

        wrap = (32'(loop_reg) > 32'(last)) ? last : FW'(loop_reg);
        f0   = (cur_reg > last) ? last : cur_reg;
        fa   = (!fin_reg && f0 == '0) ? last : f0;
        g    = (fa == '0) ? last : fa - FW'(1);
        t1   = timer_reg + 8'd1;
        step = t1 >= speed_reg;

        cur_next   = cur_reg;
        timer_next = timer_reg;
        fin_next   = fin_reg;
        wen        = 1'b0;

        if (q_push)
        begin
            case (in_data.op)
                OP_TICK:
                begin
                    if (!in_data.hold)
                    begin
                        cur_next   = f0;
                        timer_next = t1;
                        case (mode_reg)
                            MODE_LOOP:
                            begin
                                if (step)
                                begin
                                    timer_next = '0;
                                    fin_next   = (f0 == last);
                                    cur_next   = (f0 == last) ? wrap : f0 + FW'(1);
                                end
                            end
                            MODE_LOOP_ONCE:
                            begin
                                if (step)
                                begin
                                    timer_next = '0;
                                    fin_next   = (f0 == last);
                                    cur_next   = (f0 == last) ? last : f0 + FW'(1);
                                end
                            end
                            MODE_REVERSE:
                            begin
                                if (step)
                                begin
                                    timer_next = '0;
                                    fin_next   = (f0 == '0);
                                    if (f0 != '0)
                                        cur_next = f0 - FW'(1);
                                    else if (loop_reg != 8'd0)
                                        cur_next = wrap;
                                    else
                                        cur_next = last;
                                end
                            end
                            MODE_REVERSE_ONCE:
                            begin
                                // an unfinished run sitting on frame zero restarts at the top
                                cur_next = fa;
                                if (step)
                                begin
                                    timer_next = '0;
                                    if (fin_reg)
                                        cur_next = '0;
                                    else
                                    begin
                                        cur_next = g;
                                        if (g == '0)
                                            fin_next = 1'b1;
                                    end
                                end
                            end
                            MODE_PING_PONG:
                            begin
                                if (step)
                                begin
                                    timer_next = '0;
                                    if (!fin_reg)
                                    begin
                                        if (f0 == last)
                                        begin
                                            cur_next = (last != '0) ? last - FW'(1) : '0;
                                            fin_next = 1'b1;
                                        end
                                        else
                                            cur_next = f0 + FW'(1);
                                    end
                                    else if (f0 <= FW'(1))
                                    begin
                                        cur_next = '0;
                                        fin_next = 1'b0;
                                    end
                                    else
                                        cur_next = f0 - FW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                OP_SET:
                begin
                    cur_next   = (32'(in_data.index) > 32'(last)) ? last : FW'(in_data.index);
                    timer_next = '0;
                    fin_next   = 1'b0;
                end
                OP_WRITE:
                begin
                    wen = 32'(in_data.index) < MAX_FRAMES;
                end
                OP_RESTART:
                begin
                    timer_next = '0;
                    fin_next   = 1'b0;
                    if (mode_reg inside {MODE_LOOP, MODE_LOOP_ONCE, MODE_PING_PONG})
                        cur_next = '0;
                    else
                        cur_next = last;
                end
                default: ;
            endcase
        end

        q_req              = '0;
        q_req.frame        = cur_next;
        q_req.done         = fin_next;
        q_req.wen          = wen;
        q_req.waddr        = in_data.index[FW-1:0];
        q_req.tile.x       = in_data.tile_x;
        q_req.tile.y       = in_data.tile_y;
        q_req.tile.width   = in_data.tile_width;
        q_req.tile.height  = in_data.tile_height;
        q_req.tile.disp_x  = in_data.tile_disp_x;
        q_req.tile.disp_y  = in_data.tile_disp_y;
    end

endmodule

`default_nettype wire

// ===== src/sfs_queue.sv =====
// two-entry request queue between front and back
`default_nettype none

module sfs_queue #(
    parameter type entry_t = logic
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  entry_t    push_data,
    output logic      full,
    output logic      head_valid,
    input  wire logic pop,
    output entry_t    head
);
    import sfs_pkg::*;

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    entry_t            slot_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == CntW'(Depth));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // depth is a power of two so the pointers wrap on their own
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== src/sfs_back.sv =====
// back end: tile store access and result register
`default_nettype none

module sfs_back #(
    parameter int MAX_FRAMES = 256,
    parameter type req_t = logic
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  req_t                q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output sfs_pkg::out_item_t  out_data
);
    import sfs_pkg::*;

    tile_t       store_mem [MAX_FRAMES];
    tile_t       rdata_reg;
    logic [7:0]  frame_reg;
    logic        done_reg;
    logic        valid_reg, valid_next;

    // the result register doubles as the store's read register
    assign q_pop = q_valid && (!valid_reg || !out_stall);

    always_comb
    begin
        if (q_pop)
            valid_next = 1'b1;
        else
            valid_next = valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_head.wen)
                store_mem[q_head.waddr] <= q_head.tile;
            // a write to the frame being shown is seen by the same request
            if (q_head.wen && q_head.waddr == q_head.frame)
                rdata_reg <= q_head.tile;
            else
                rdata_reg <= store_mem[q_head.frame];
            frame_reg <= 8'(q_head.frame);
            done_reg  <= q_head.done;
        end
    end

    assign out_valid           = valid_reg;
    assign out_data.frame      = frame_reg;
    assign out_data.done_res   = done_reg;
    assign out_data.spr_x      = rdata_reg.x;
    assign out_data.spr_y      = rdata_reg.y;
    assign out_data.spr_width  = rdata_reg.width;
    assign out_data.spr_height = rdata_reg.height;
    assign out_data.spr_disp_x = rdata_reg.disp_x;
    assign out_data.spr_disp_y = rdata_reg.disp_y;

endmodule

`default_nettype wire

// ===== src/sprite_frame_sequencer.sv =====
// sprite frame sequencer top level
// a request is registered in the queue and then in the result register before its result is presented
// throughput: one request per cycle while out_stall is low; the tile store is read and written in the same pop
// the two-entry queue lets the front keep taking requests while a result is stalled
// reset: frame, timer, finished flag, queue and result valid cleared; config to defaults
// the tile store has no reset and holds garbage until written
`default_nettype none
`include "assert_macros.svh"

module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire sfs_pkg::cfg_addr_t             cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire sfs_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output sfs_pkg::out_item_t                  out_data
);
    import sfs_pkg::*;

    localparam int FW = $clog2(MAX_FRAMES);

    typedef struct packed {
        logic [FW-1:0] frame;
        logic          done;
        logic          wen;
        logic [FW-1:0] waddr;
        tile_t         tile;
    } req_t;

    req_t q_req;
    req_t q_head;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    sfs_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .req_t      (req_t)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_req     (q_req)
    );

    sfs_queue #(
        .entry_t (req_t)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_req),
        .full       (q_full),
        .head_valid (q_valid),
        .pop        (q_pop),
        .head       (q_head)
    );

    sfs_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .req_t      (req_t)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `SFS_ASSERT_NOW(a_full_has_head, q_full, q_valid, "queue full but empty head")
    `SFS_ASSERT_NOW(a_pop_when_free, q_pop, (!out_valid || !out_stall), "pop over held result")
    `SFS_ASSERT_NEXT(a_pop_gives_result, q_pop, out_valid, "popped request gave no result")
    `SFS_ASSERT_NEXT(a_write_bypass, (q_pop && q_head.wen && q_head.waddr == q_head.frame), (out_data.spr_x == $past(q_head.tile.x) && out_data.spr_disp_y == $past(q_head.tile.disp_y)), "tile write not seen by its own request")

endmodule

`default_nettype wire
